FILE: rtl/core/sm3_pkg.sv
`default_nettype none

package sm3_pkg;

    localparam int ROUNDS = 64;
    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int COUNT_W = 55;

    localparam logic [255:0] INIT_VALUE = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PAD,
        ST_FINAL,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic take_byte;    // store the input byte
        logic start;        // load schedule and working words
        logic round;        // run one round
        logic fold;         // xor working words into chaining value
        logic pad;          // write pad, zero fill and maybe length
        logic len_block;    // zero block and write length
        logic emit_next;    // advance output word
        logic clear_msg;    // back to initial value
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       block_full;   // this byte completes a block
        logic       pad_two;      // pad needs a second block
        logic       last_round;
        logic       last_out;
    } stat_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sm3_datapath.sv
`default_nettype none

module sm3_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sm3_pkg::cmd_t   cmd,
    input  wire logic [7:0]      data_byte,
    output sm3_pkg::stat_t       stat,
    output logic [31:0]          digest_word,
    output logic [2:0]           word_index
);
    import sm3_pkg::*;

    logic [31:0] buf_reg [16];
    logic [31:0] buf_next [16];
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    logic [31:0] w_reg [8];
    logic [31:0] w_next [8];
    logic [31:0] cv_reg [8];
    logic [31:0] cv_next [8];
    logic [5:0]  pos_reg, pos_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  oidx_reg, oidx_next;

    logic [31:0] wj, wj4, tc, a12, ss1, ss2, ff, gg, tt1, tt2, wnew;
    logic [63:0] bits;
    logic [3:0]  widx;
    logic [4:0]  sh;

    // one sm3 round and message expansion
    always_comb
    begin
        wj  = win_reg[rnd_reg[3:0]];
        wj4 = win_reg[rnd_reg[3:0] + 4'd4];
        tc  = (rnd_reg < 6'd16) ? T_LOW : T_HIGH;
        a12 = rotl(w_reg[0], 5'd12);
        ss1 = rotl(a12 + w_reg[4] + rotl(tc, rnd_reg[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (rnd_reg < 6'd16)
        begin
            ff = w_reg[0] ^ w_reg[1] ^ w_reg[2];
            gg = w_reg[4] ^ w_reg[5] ^ w_reg[6];
        end
        else
        begin
            ff = (w_reg[0] & w_reg[1]) | (w_reg[0] & w_reg[2]) | (w_reg[1] & w_reg[2]);
            gg = (w_reg[4] & w_reg[5]) | (~w_reg[4] & w_reg[6]);
        end
        tt1 = ff + w_reg[3] + ss2 + (wj ^ wj4);
        tt2 = gg + w_reg[7] + ss1 + wj;
        wnew = p1(wj ^ win_reg[rnd_reg[3:0] + 4'd7]
                  ^ rotl(win_reg[rnd_reg[3:0] + 4'd13], 5'd15))
               ^ rotl(win_reg[rnd_reg[3:0] + 4'd3], 5'd7)
               ^ win_reg[rnd_reg[3:0] + 4'd10];
    end

    assign bits = {cnt_reg, pos_reg, 3'b000};
    assign widx = pos_reg[5:2];
    assign sh   = {~pos_reg[1:0], 3'b000};

    // next state of all storage
    always_comb
    begin
        buf_next = buf_reg;
        win_next = win_reg;
        w_next   = w_reg;
        cv_next  = cv_reg;
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        rnd_next = rnd_reg;
        oidx_next = oidx_reg;
        if (cmd.take_byte)
        begin
            if (pos_reg[1:0] == 2'd0)
                buf_next[widx] = 32'(data_byte) << sh;
            else
                buf_next[widx] = buf_reg[widx] | (32'(data_byte) << sh);
            pos_next = pos_reg + 6'd1;
            if (pos_reg == 6'd63)
                cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.pad)
        begin
            if (pos_reg[1:0] == 2'd0)
                buf_next[widx] = 32'(PAD_BYTE) << sh;
            else
                buf_next[widx] = buf_reg[widx] | (32'(PAD_BYTE) << sh);
            for (int k = 0; k < 16; k++)
                if (4'(k) > widx)
                    buf_next[k] = '0;
            if (pos_reg <= 6'd55)
            begin
                buf_next[14] = bits[63:32];
                buf_next[15] = bits[31:0];
            end
        end
        if (cmd.len_block)
        begin
            for (int k = 0; k < 14; k++)
                buf_next[k] = '0;
            buf_next[14] = bits[63:32];
            buf_next[15] = bits[31:0];
        end
        if (cmd.round)
        begin
            w_next[3] = w_reg[2];
            w_next[2] = rotl(w_reg[1], 5'd9);
            w_next[1] = w_reg[0];
            w_next[0] = tt1;
            w_next[7] = w_reg[6];
            w_next[6] = rotl(w_reg[5], 5'd19);
            w_next[5] = w_reg[4];
            w_next[4] = p0(tt2);
            win_next[rnd_reg[3:0]] = wnew;
            rnd_next = rnd_reg + 6'd1;
        end
        if (cmd.fold)
        begin
            for (int k = 0; k < 8; k++)
                cv_next[k] = cv_reg[k] ^ w_reg[k];
            oidx_next = '0;
        end
        // load the block as written this cycle and the chaining value after any fold
        if (cmd.start)
        begin
            win_next = buf_next;
            w_next   = cv_next;
            rnd_next = '0;
        end
        if (cmd.emit_next)
            oidx_next = oidx_reg + 3'd1;
        if (cmd.clear_msg)
        begin
            for (int k = 0; k < 8; k++)
                cv_next[k] = INIT_VALUE[255-32*k -: 32];
            pos_next = '0;
            cnt_next = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 8; k++)
                cv_reg[k] <= INIT_VALUE[255-32*k -: 32];
            pos_reg  <= '0;
            cnt_reg  <= '0;
            rnd_reg  <= '0;
            oidx_reg <= '0;
        end
        else
        begin
            cv_reg   <= cv_next;
            pos_reg  <= pos_next;
            cnt_reg  <= cnt_next;
            rnd_reg  <= rnd_next;
            oidx_reg <= oidx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        win_reg <= win_next;
        w_reg   <= w_next;
    end

    assign stat.block_full = (pos_reg == 6'd63);
    assign stat.pad_two    = (pos_reg > 6'd55);
    assign stat.last_round = (rnd_reg == 6'd63);
    assign stat.last_out   = (oidx_reg == 3'd7);
    assign digest_word     = cv_reg[oidx_reg];
    assign word_index      = oidx_reg;

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round |=> (rnd_reg == $past(rnd_reg) + 6'd1))
        else $error("round counter did not advance");
    a_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.round && cmd.start))
        else $error("round and start together");
    a_clear_pos: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_msg |=> (pos_reg == 6'd0 && cnt_reg == '0))
        else $error("message state not cleared");

endmodule

`default_nettype wire

FILE: rtl/core/sm3_ctrl.sv
`default_nettype none

module sm3_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sm3_pkg::in_beat_t in_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire sm3_pkg::stat_t   stat,
    output sm3_pkg::cmd_t         cmd
);
    import sm3_pkg::*;

    state_t state_reg, state_next;
    logic   final_reg, final_next;   // compressing a block that ends the message
    logic   two_reg, two_next;       // a length-only block follows
    logic   eom_reg, eom_next;       // pad pending after a full block
    logic   acc;

    assign acc = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        final_next = final_reg;
        two_next   = two_reg;
        eom_next   = eom_reg;
        case (state_reg)
            ST_IDLE:
                if (acc)
                begin
                    eom_next = in_data.end_of_message;
                    if (in_data.byte_valid && stat.block_full)
                    begin
                        final_next = 1'b0;
                        state_next = ST_ROUND;
                    end
                    else if (in_data.end_of_message)
                        state_next = ST_PAD;
                end
            ST_ROUND:
                if (stat.last_round)
                    state_next = ST_FINAL;
            ST_FINAL:
                if (final_reg && !two_reg)
                    state_next = ST_OUT;
                else if (final_reg && two_reg)
                begin
                    two_next   = 1'b0;
                    state_next = ST_ROUND;
                end
                else if (eom_reg)
                begin
                    eom_next   = 1'b0;
                    state_next = ST_PAD;
                end
                else
                    state_next = ST_IDLE;
            ST_PAD:
            begin
                final_next = 1'b1;
                two_next   = stat.pad_two;
                eom_next   = 1'b0;
                state_next = ST_ROUND;
            end
            ST_OUT:
                if (out_ready && stat.last_out)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take_byte = acc && in_data.byte_valid;
                cmd.start     = acc && in_data.byte_valid && stat.block_full;
            end
            ST_ROUND:
                cmd.round = 1'b1;
            ST_FINAL:
            begin
                cmd.fold      = 1'b1;
                cmd.len_block = final_reg && two_reg;
                cmd.start     = final_reg && two_reg;
            end
            ST_PAD:
            begin
                cmd.pad   = 1'b1;
                cmd.start = 1'b1;
            end
            ST_OUT:
            begin
                cmd.emit_next = out_ready;
                cmd.clear_msg = out_ready && stat.last_out;
            end
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            final_reg <= 1'b0;
            two_reg   <= 1'b0;
            eom_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
            two_reg   <= two_next;
            eom_reg   <= eom_next;
        end
    end

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");
    a_round_to_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && stat.last_round) |=> state_reg == ST_FINAL)
        else $error("compression did not finish");
    a_pad_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD) |=> (state_reg == ST_ROUND && final_reg))
        else $error("pad did not start final compression");

endmodule

`default_nettype wire

FILE: rtl/core/sm3_hash_engine.sv
`default_nettype none

// SM3 hash engine. Message bytes arrive one per beat and are packed big-endian;
// an end-of-message beat pads the message and eight digest beats follow, word 0
// first, last one flagged. A byte that fills a block starts a compression, during
// which input waits: one round per cycle through a single round unit over 64
// rounds, plus load and fold. Closing a message costs one or two such
// compressions plus a pad step, then eight output beats; new input waits until
// the last digest word is taken.
module sm3_hash_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sm3_pkg::in_beat_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sm3_pkg::out_beat_t      out_data
);
    import sm3_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic [31:0] dword;
    logic [2:0]  widx;

    sm3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sm3_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (in_data.data_byte),
        .stat        (stat),
        .digest_word (dword),
        .word_index  (widx)
    );

    assign out_data.digest_word = dword;
    assign out_data.word_index  = widx;
    assign out_data.last_word   = (widx == 3'd7);

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none

module tb;
    import sm3_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;

    sm3_hash_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // digest predictor and store of expected digest beats
    class digest_board;
        logic [31:0] cv [8];
        logic [31:0] msg_words [16];
        logic [5:0]  fill;
        logic [54:0] nblocks;
        out_beat_t   pending [$];
        int          errors;
        int          words_seen;
        int          messages;

        function new();
            errors = 0;
            words_seen = 0;
            messages = 0;
            restart();
        endfunction

        function void restart();
            for (int k = 0; k < 8; k++)
                cv[k] = INIT_VALUE[255 - 32 * k -: 32];
            fill = '0;
            nblocks = '0;
        endfunction

        function logic [31:0] rol(logic [31:0] x, int n);
            n = n % 32;
            if (n == 0)
                return x;
            return (x << n) | (x >> (32 - n));
        endfunction

        // one block through the 64 rounds
        function void crunch();
            logic [31:0] w [68];
            logic [31:0] a, b, c, d, e, f, g, h;
            logic [31:0] tc, a12, ss1, ss2, ff, gg, t1, t2, x;
            for (int j = 0; j < 16; j++)
                w[j] = msg_words[j];
            for (int j = 16; j < 68; j++)
            begin
                x = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
                w[j] = x ^ rol(x, 15) ^ rol(x, 23) ^ rol(w[j-13], 7) ^ w[j-6];
            end
            a = cv[0]; b = cv[1]; c = cv[2]; d = cv[3];
            e = cv[4]; f = cv[5]; g = cv[6]; h = cv[7];
            for (int j = 0; j < 64; j++)
            begin
                tc = (j < 16) ? T_LOW : T_HIGH;
                a12 = rol(a, 12);
                ss1 = rol(a12 + e + rol(tc, j % 32), 7);
                ss2 = ss1 ^ a12;
                if (j < 16)
                begin
                    ff = a ^ b ^ c;
                    gg = e ^ f ^ g;
                end
                else
                begin
                    ff = (a & b) | (a & c) | (b & c);
                    gg = (e & f) | (~e & g);
                end
                t1 = ff + d + ss2 + (w[j] ^ w[j+4]);
                t2 = gg + h + ss1 + w[j];
                d = c; c = rol(b, 9); b = a; a = t1;
                h = g; g = rol(f, 19); f = e;
                e = t2 ^ rol(t2, 9) ^ rol(t2, 17);
            end
            cv[0] ^= a; cv[1] ^= b; cv[2] ^= c; cv[3] ^= d;
            cv[4] ^= e; cv[5] ^= f; cv[6] ^= g; cv[7] ^= h;
        endfunction

        function void place(logic [5:0] pos, logic [7:0] v);
            int sh;
            sh = (3 - pos[1:0]) * 8;
            if (pos[1:0] == 2'd0)
                msg_words[pos[5:2]] = 32'(v) << sh;
            else
                msg_words[pos[5:2]] |= 32'(v) << sh;
        endfunction

        // note an accepted input beat
        function void note_input(in_beat_t it);
            logic [63:0] nbits;
            out_beat_t   ob;
            if (it.byte_valid)
            begin
                place(fill, it.data_byte);
                fill = fill + 6'd1;
                if (fill == 6'd0)
                begin
                    crunch();
                    nblocks = nblocks + 55'd1;
                end
            end
            if (!it.end_of_message)
                return;
            nbits = ({9'd0, nblocks} << 9) + (64'(fill) << 3);
            place(fill, PAD_BYTE);
            for (int k = fill[5:2] + 1; k < 16; k++)
                msg_words[k] = '0;
            if (fill > 6'd55)
            begin
                crunch();
                for (int k = 0; k < 14; k++)
                    msg_words[k] = '0;
            end
            msg_words[14] = nbits[63:32];
            msg_words[15] = nbits[31:0];
            crunch();
            for (int k = 0; k < 8; k++)
            begin
                ob.digest_word = cv[k];
                ob.word_index = 3'(k);
                ob.last_word = (k == 7);
                pending.push_back(ob);
            end
            messages++;
            restart();
        endfunction

        // compare one digest beat with the oldest expectation
        function void check_output(out_beat_t got);
            out_beat_t want;
            words_seen++;
            if (pending.size() == 0)
            begin
                $error("digest beat with nothing expected: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.digest_word !== want.digest_word)
            begin
                $error("digest_word expected %h got %h", want.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== want.word_index)
            begin
                $error("word_index expected %0d got %0d", want.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== want.last_word)
            begin
                $error("last_word expected %0b got %0b", want.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    digest_board board;
    int          cycles;
    int          beats_sent;
    localparam int CYCLE_LIMIT = 400000;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_input(in_data);
        if (rst_n && out_valid && out_ready)
            board.check_output(out_data);
    end

    // receiver stalls
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (cycles % 2000 < 300)
                gap = 0;
            else
                gap = $urandom_range(0, 8);
            if (gap == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
                out_ready <= 1'b1;
            end
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    // valid stays high from the previous beat until this beat replaces it or a gap drops it
    task automatic send_beat(logic [7:0] b, logic v, logic eom, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data.data_byte      <= b;
        in_data.byte_valid     <= v;
        in_data.end_of_message <= eom;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_message(int len, bit burst);
        for (int k = 0; k < len; k++)
            send_beat(8'($urandom), 1'b1, (k == len - 1), burst);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int len;
        int pick;
        board = new();
        cycles = 0;
        beats_sent = 0;
        in_valid = 1'b0;
        in_data = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty message, then the classic "abc"
        send_beat(8'h00, 1'b0, 1'b1, 0);
        send_beat(8'h61, 1'b1, 1'b0, 0);
        send_beat(8'h62, 1'b1, 1'b0, 0);
        send_beat(8'h63, 1'b1, 1'b1, 0);
        // extremes, an idle beat, byte on end beat
        send_beat(8'hFF, 1'b1, 1'b0, 0);
        send_beat(8'hAA, 1'b0, 1'b0, 0);
        send_beat(8'h00, 1'b1, 1'b0, 0);
        send_beat(8'h55, 1'b1, 1'b1, 0);
        // empty close after bytes
        send_beat(8'h12, 1'b1, 1'b0, 0);
        send_beat(8'hFF, 1'b0, 1'b1, 0);
        // sender holds off until all digests are out
        wait_drained();

        // pad boundaries: 55, 56 (two final blocks), 63, 64, 120 bytes
        send_message(55, 1);
        send_message(56, 0);
        send_message(63, 0);
        send_message(64, 1);
        wait_drained();
        send_message(120, 0);

        // random messages, mostly short, some noise beats
        while (beats_sent < 480)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                len = $urandom_range(1, 12);
            else if (pick < 9)
                len = $urandom_range(50, 70);
            else
                len = $urandom_range(100, 140);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(8'($urandom), 1'b0, 1'b0, 0);
                send_beat(8'($urandom), 1'b1, (k == len - 1), pick == 3);
            end
            if ($urandom_range(0, 4) == 0)
                send_beat(8'($urandom), 1'b0, 1'b1, 0);
        end

        wait_drained();
        repeat (200) @(posedge clk);
        $display("covered %0d input beats, %0d messages, %0d digest words checked",
                 beats_sent, board.messages, board.words_seen);
        $display("messages included empty ones, pad boundary lengths and multi-block ones");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/sm3_pkg.sv
rtl/core/sm3_datapath.sv
rtl/core/sm3_ctrl.sv
rtl/core/sm3_hash_engine.sv
tb/sv/tb.sv
